[rtl/core/mrcs_pkg.sv]
// ----------------------------------------------------------------------------
// mrcs_pkg: shared definitions for the register and coil store
// Field widths, the default store size and the access command codes.
// ----------------------------------------------------------------------------
package mrcs_pkg;

  localparam int unsigned STORE_WORDS_DEF = 1024;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 14;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned WORD_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_RD_REG  = 2'd0,
    CMD_WR_REG  = 2'd1,
    CMD_RD_COIL = 2'd2,
    CMD_WR_COIL = 2'd3
  } cmd_e;

endpackage

[rtl/core/mrcs_ram.sv]
// ----------------------------------------------------------------------------
// mrcs_ram: word bank of the store
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module mrcs_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned IDX_W = 9
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [IDX_W-1:0]              waddr_i,
  input  logic [mrcs_pkg::WORD_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [IDX_W-1:0]              raddr_i,
  output logic [mrcs_pkg::WORD_W-1:0]   rdata_o
);
  import mrcs_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old word on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/modbus_register_coil_store_top.sv]
// ----------------------------------------------------------------------------
// modbus_register_coil_store_top: holding register and coil store
// Serves one register or coil-group access per transfer on a store of
// 16-bit words split into an even-word bank and an odd-word bank.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o    | command, byte_swap, address,
//          |           |                            | count, write_data
//  out     | output    | out_valid_o / out_ready_i  | read_data, in_range
//
//  One transfer per cycle sustained while the consumer takes results; each
//  result passes the bank read with the input register, then the
//  read-modify-write into the result register.
//  The figure is set by the one write port of each bank: every access writes
//  at most one word per bank, so one access per cycle fits.
//  After reset a clearing pass writes zero to every index of both banks;
//  in_ready_o stays low until the pass is over.
//  A stalled result holds the access stage, which holds the input side.
//
module modbus_register_coil_store_top #(
  parameter int unsigned STORE_WORDS = mrcs_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mrcs_pkg::CMD_W-1:0]    command_i,
  input  logic                          byte_swap_i,
  input  logic [mrcs_pkg::ADDR_W-1:0]   address_i,
  input  logic [mrcs_pkg::COUNT_W-1:0]  count_i,
  input  logic [mrcs_pkg::WORD_W-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mrcs_pkg::WORD_W-1:0]   read_data_o,
  output logic                          in_range_o
);
  import mrcs_pkg::*;

  // Even words live in one bank, odd words in the other, so a coil group
  // that spans two neighbouring words reads and writes each bank once.
  localparam int unsigned E_DEPTH    = (STORE_WORDS + 1) / 2;
  localparam int unsigned O_DEPTH    = STORE_WORDS / 2;
  localparam int unsigned IDX_W      = (E_DEPTH > 1) ? $clog2(E_DEPTH) : 1;
  localparam int unsigned REG_LIMIT  = STORE_WORDS - 1;
  localparam int unsigned COIL_LIMIT = 2 * STORE_WORDS - 1;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_idx_q, clr_idx_d;
  logic               clearing;

  // handshake
  logic               in_fire;
  logic               s1_advance;

  // access stage
  logic               s1_valid_q;
  cmd_e               s1_cmd_q;
  logic               s1_swap_q;
  logic               s1_pass_q;
  logic               s1_wlsb_q;
  logic               s1_bodd_q;
  logic [2:0]         s1_off_q;
  logic [COUNT_W-1:0] s1_n_q;
  logic [WORD_W-1:0]  s1_wdata_q;
  logic [IDX_W-1:0]   s1_eidx_q;
  logic [IDX_W-1:0]   s1_oidx_q;

  // decode of the incoming item
  cmd_e               in_cmd;
  logic               in_is_reg;
  logic [ADDR_W-1:0]  word_sel;
  logic [ADDR_W:0]    word_inc;
  logic [IDX_W-1:0]   rd_eidx;
  logic [IDX_W-1:0]   rd_oidx;
  logic               in_pass;
  logic [COUNT_W-1:0] in_n;

  // bank ports
  logic [WORD_W-1:0]  e_rdata, o_rdata;
  logic               e_we, o_we;
  logic [WORD_W-1:0]  e_wdata, o_wdata;
  logic               ram_e_we, ram_o_we;
  logic [IDX_W-1:0]   ram_e_waddr, ram_o_waddr;
  logic [WORD_W-1:0]  ram_e_wdata, ram_o_wdata;

  // forwarding of the write that lands on the same edge as a read
  logic               e_fwd_q, o_fwd_q;
  logic [WORD_W-1:0]  e_fwd_data_q, o_fwd_data_q;

  // access datapath
  logic [WORD_W-1:0]  even_word, odd_word, lo_word, hi_word;
  logic [WORD_W-1:0]  window, new_win, mask16, coil_rd, rd_val;
  logic [7:0]         fmask8;
  logic               lo_we, hi_we;
  logic [WORD_W-1:0]  lo_new, hi_new;

  // output register
  logic               out_valid_q;
  logic [WORD_W-1:0]  read_data_q;
  logic               in_range_q;

  // --------------------------------------------------------------------------
  // Clearing pass and run state
  // --------------------------------------------------------------------------
  assign clearing = (state_q == ST_CLEAR);

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == IDX_W'(E_DEPTH - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the access stage moves on whenever the result register is free
  // or is being emptied this cycle.
  // --------------------------------------------------------------------------
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing && (!s1_valid_q || s1_advance);
  assign in_fire    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Decode: word of the access (register address, or the word holding the
  // first coil byte) and the bank indices of that word and the next one.
  // --------------------------------------------------------------------------
  always_comb begin
    in_cmd    = cmd_e'(command_i);
    in_is_reg = (in_cmd == CMD_RD_REG) || (in_cmd == CMD_WR_REG);
    word_sel  = in_is_reg ? address_i : {4'b0000, address_i[ADDR_W-1:4]};
    word_inc  = {1'b0, word_sel} + {{ADDR_W{1'b0}}, 1'b1};
    rd_eidx   = IDX_W'(word_inc[ADDR_W:1]);
    rd_oidx   = IDX_W'(word_sel[ADDR_W-1:1]);
    if (in_is_reg) begin
      in_pass = (32'(address_i) < REG_LIMIT);
    end else begin
      in_pass = (32'(address_i[ADDR_W-1:3]) < COIL_LIMIT);
    end
    // clamp oversized coil groups to a full byte
    in_n = (count_i > COUNT_W'(8)) ? COUNT_W'(8) : count_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      e_fwd_q    <= 1'b0;
      o_fwd_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        e_fwd_q    <= e_we && (s1_eidx_q == rd_eidx);
        o_fwd_q    <= o_we && (s1_oidx_q == rd_oidx);
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q     <= in_cmd;
      s1_swap_q    <= byte_swap_i;
      s1_pass_q    <= in_pass;
      s1_wlsb_q    <= word_sel[0];
      s1_bodd_q    <= address_i[3];
      s1_off_q     <= address_i[2:0];
      s1_n_q       <= in_n;
      s1_wdata_q   <= write_data_i;
      s1_eidx_q    <= rd_eidx;
      s1_oidx_q    <= rd_oidx;
      e_fwd_data_q <= e_wdata;
      o_fwd_data_q <= o_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Banks
  // --------------------------------------------------------------------------
  assign ram_e_we    = clearing ? 1'b1 : e_we;
  assign ram_e_waddr = clearing ? clr_idx_q : s1_eidx_q;
  assign ram_e_wdata = clearing ? '0 : e_wdata;
  // the odd bank is one entry shorter for an odd store size
  assign ram_o_we    = clearing ? (32'(clr_idx_q) < O_DEPTH) : o_we;
  assign ram_o_waddr = clearing ? clr_idx_q : s1_oidx_q;
  assign ram_o_wdata = clearing ? '0 : o_wdata;

  mrcs_ram #(
    .DEPTH (E_DEPTH),
    .IDX_W (IDX_W)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (ram_e_we),
    .waddr_i (ram_e_waddr),
    .wdata_i (ram_e_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_eidx),
    .rdata_o (e_rdata)
  );

  mrcs_ram #(
    .DEPTH (O_DEPTH),
    .IDX_W (IDX_W)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (ram_o_we),
    .waddr_i (ram_o_waddr),
    .wdata_i (ram_o_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_oidx),
    .rdata_o (o_rdata)
  );

  // --------------------------------------------------------------------------
  // Access: merge the two words, build the 16-bit coil window, read or modify
  // it or the register word, and split the result back into the banks.
  // --------------------------------------------------------------------------
  always_comb begin
    even_word = e_fwd_q ? e_fwd_data_q : e_rdata;
    odd_word  = o_fwd_q ? o_fwd_data_q : o_rdata;
    lo_word   = s1_wlsb_q ? odd_word : even_word;
    hi_word   = s1_wlsb_q ? even_word : odd_word;
    // an odd first byte is the high byte of the lower word
    window    = s1_bodd_q ? {hi_word[7:0], lo_word[15:8]} : lo_word;
    fmask8    = 8'((9'd1 << s1_n_q) - 9'd1);
    mask16    = {8'h00, fmask8} << s1_off_q;
    coil_rd   = (window >> s1_off_q) & {8'h00, fmask8};
    new_win   = (window & ~mask16) | ({8'h00, s1_wdata_q[7:0] & fmask8} << s1_off_q);

    rd_val = '0;
    lo_we  = 1'b0;
    hi_we  = 1'b0;
    lo_new = lo_word;
    hi_new = {hi_word[15:8], new_win[15:8]};
    unique case (s1_cmd_q)
      CMD_RD_REG: begin
        rd_val = s1_swap_q ? {lo_word[7:0], lo_word[15:8]} : lo_word;
      end
      CMD_WR_REG: begin
        lo_we  = 1'b1;
        lo_new = s1_swap_q ? {s1_wdata_q[7:0], s1_wdata_q[15:8]} : s1_wdata_q;
      end
      CMD_RD_COIL: begin
        rd_val = coil_rd;
      end
      CMD_WR_COIL: begin
        lo_we  = 1'b1;
        hi_we  = s1_bodd_q;
        lo_new = s1_bodd_q ? {new_win[7:0], lo_word[7:0]} : new_win;
      end
      default: begin
        rd_val = '0;
      end
    endcase

    // drop every effect of a failed bound check
    if (!s1_pass_q) begin
      rd_val = '0;
      lo_we  = 1'b0;
      hi_we  = 1'b0;
    end

    e_we    = s1_advance && (s1_wlsb_q ? hi_we : lo_we);
    o_we    = s1_advance && (s1_wlsb_q ? lo_we : hi_we);
    e_wdata = s1_wlsb_q ? hi_new : lo_new;
    o_wdata = s1_wlsb_q ? lo_new : hi_new;
  end

  // --------------------------------------------------------------------------
  // Result register: hold while the consumer stalls.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      read_data_q <= rd_val;
      in_range_q  <= s1_pass_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign in_range_o  = in_range_q;

`ifndef SYNTH
  a_no_transfer_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o
  ) else $error("input taken during clearing pass");

  a_write_only_on_commit : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ram_e_we || ram_o_we) |-> (clearing || s1_advance)
  ) else $error("bank written outside commit or clearing");

  a_failed_reads_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_range_o) |-> (read_data_o == '0)
  ) else $error("failed access returned data");

  a_stage_holds_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_advance) |=> (s1_valid_q && $stable(s1_eidx_q) && $stable(s1_oidx_q))
  ) else $error("access stage changed while stalled");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the holding register and coil store
// Walks a short table of directed accesses, then about 1750 random ones
// that are biased towards a few hot windows of the store so reads meet
// earlier writes. Each accepted access is run through a local image of the
// store to work out the expected result, unless its directed row types one in.
// Both handshake sides idle at random, and results are checked in order as they transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import mrcs_pkg::*;

  localparam int unsigned STORE_WORDS     = STORE_WORDS_DEF;
  localparam int unsigned RANDOM_ACCESSES = 1750;
  localparam int unsigned PIPE_LATENCY    = 2;
  localparam int unsigned DRAIN_CYCLES    = 8 * PIPE_LATENCY;
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned DIRECTED_ROWS   = 24;

  // One access as it crosses the input channel.
  typedef struct packed {
    cmd_e                command;
    logic                byte_swap;
    logic [ADDR_W-1:0]   address;
    logic [COUNT_W-1:0]  count;
    logic [WORD_W-1:0]   write_data;
  } access_t;

  // One result as it crosses the output channel.
  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              in_range;
  } response_t;

  // Directed row: an access plus, where it is obvious, the result typed in.
  typedef struct packed {
    access_t   acc;
    logic      typed;
    response_t resp;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CMD_W-1:0]   command_i;
  logic               byte_swap_i;
  logic [ADDR_W-1:0]  address_i;
  logic [COUNT_W-1:0] count_i;
  logic [WORD_W-1:0]  write_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [WORD_W-1:0]  read_data_o;
  logic               in_range_o;

  // Typed expectation travelling alongside the access being offered.
  logic               row_typed;
  response_t          row_expect;

  logic [WORD_W-1:0]  store_image [STORE_WORDS];
  response_t          awaited_responses [$];
  int unsigned        fail_count   = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        result_count = 0;

  access_t            next_access;
  access_t            seen_access;
  response_t          model_resp;
  response_t          seen_resp;
  response_t          want_resp;
  int unsigned        pick;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // fresh store reads back zero, top register is out of bounds
    '{'{CMD_RD_REG,  1'b0, 14'd0,     4'd1,  16'h0000}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_REG,  1'b1, 14'd1022,  4'd15, 16'hFFFF}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_REG,  1'b0, 14'd1023,  4'd1,  16'h0000}, 1'b1, '{16'h0000, 1'b0}},
    '{'{CMD_WR_REG,  1'b1, 14'd16383, 4'd8,  16'hFFFF}, 1'b1, '{16'h0000, 1'b0}},
    // register writes in both byte orders, read back both ways
    '{'{CMD_WR_REG,  1'b0, 14'd0,     4'd1,  16'h1234}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_REG,  1'b0, 14'd0,     4'd1,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    '{'{CMD_RD_REG,  1'b1, 14'd0,     4'd1,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    '{'{CMD_WR_REG,  1'b1, 14'd1022,  4'd0,  16'hABCD}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_REG,  1'b0, 14'd1022,  4'd1,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    // coil group straddling a byte boundary
    '{'{CMD_WR_COIL, 1'b0, 14'd5,     4'd8,  16'hFFFF}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_COIL, 1'b0, 14'd0,     4'd8,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    // oversized count acts as eight, zero count touches nothing
    '{'{CMD_RD_COIL, 1'b0, 14'd5,     4'd15, 16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    '{'{CMD_RD_COIL, 1'b0, 14'd5,     4'd0,  16'hFFFF}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_WR_COIL, 1'b0, 14'd3,     4'd0,  16'hFFFF}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_REG,  1'b0, 14'd0,     4'd1,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    // last legal coil byte reaches into the top word; swap has no say
    '{'{CMD_WR_COIL, 1'b1, 14'd16375, 4'd8,  16'h00A5}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_COIL, 1'b1, 14'd16368, 4'd8,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    '{'{CMD_RD_COIL, 1'b0, 14'd16376, 4'd1,  16'h0000}, 1'b1, '{16'h0000, 1'b0}},
    '{'{CMD_WR_COIL, 1'b0, 14'd16383, 4'd15, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0}},
    '{'{CMD_RD_REG,  1'b1, 14'd1022,  4'd1,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    '{'{CMD_WR_COIL, 1'b0, 14'd7,     4'd9,  16'h0000}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_COIL, 1'b1, 14'd0,     4'd12, 16'h0000}, 1'b0, '{16'h0000, 1'b0}},
    '{'{CMD_WR_REG,  1'b0, 14'd1,     4'd1,  16'h8001}, 1'b1, '{16'h0000, 1'b1}},
    '{'{CMD_RD_COIL, 1'b0, 14'd15,    4'd3,  16'h0000}, 1'b0, '{16'h0000, 1'b0}}
  };

  modbus_register_coil_store_top #(
    .STORE_WORDS(STORE_WORDS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .byte_swap_i  (byte_swap_i),
    .address_i    (address_i),
    .count_i      (count_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .in_range_o   (in_range_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Byte view of the image: byte 2w is the low half of word w.
  function automatic logic [7:0] image_byte(input int unsigned byte_idx);
    int unsigned word_idx;
    word_idx = byte_idx >> 1;
    if (word_idx >= STORE_WORDS) return 8'h00;
    return byte_idx[0] ? store_image[word_idx][15:8] : store_image[word_idx][7:0];
  endfunction

  function automatic void patch_image_byte(input int unsigned byte_idx,
                                           input logic [7:0] value);
    int unsigned word_idx;
    word_idx = byte_idx >> 1;
    if (word_idx >= STORE_WORDS) return;
    if (byte_idx[0]) store_image[word_idx][15:8] = value;
    else             store_image[word_idx][7:0]  = value;
  endfunction

  // Run one access against the image and return the result it yields.
  function automatic response_t apply_access(input access_t acc);
    response_t   resp;
    int unsigned group_bits;
    int unsigned byte_idx;
    int unsigned bit_offset;
    logic [15:0] window;
    logic [15:0] group_mask;
    logic [15:0] placed_mask;
    logic [15:0] word;
    resp = '0;
    case (acc.command)
      CMD_RD_REG, CMD_WR_REG: begin
        if (32'(acc.address) + 1 < STORE_WORDS) begin
          resp.in_range = 1'b1;
          if (acc.command == CMD_RD_REG) begin
            word = store_image[acc.address];
            resp.read_data = acc.byte_swap ? {word[7:0], word[15:8]} : word;
          end else begin
            word = acc.write_data;
            store_image[acc.address] = acc.byte_swap ? {word[7:0], word[15:8]} : word;
          end
        end
      end
      default: begin
        group_bits = (acc.count > 4'd8) ? 8 : 32'(acc.count);
        byte_idx   = 32'(acc.address >> 3);
        bit_offset = 32'(acc.address[2:0]);
        if (byte_idx + 1 < 2 * STORE_WORDS) begin
          group_mask     = 16'((32'd1 << group_bits) - 1);
          window         = {image_byte(byte_idx + 1), image_byte(byte_idx)};
          resp.in_range  = 1'b1;
          if (acc.command == CMD_RD_COIL) begin
            resp.read_data = (window >> bit_offset) & group_mask;
          end else if (group_bits != 0) begin
            placed_mask = group_mask << bit_offset;
            window = (window & ~placed_mask) | ((acc.write_data & group_mask) << bit_offset);
            patch_image_byte(byte_idx, window[7:0]);
            patch_image_byte(byte_idx + 1, window[15:8]);
          end
        end
      end
    endcase
    return resp;
  endfunction

  // Offer one access after an idle gap and hold it until it transfers.
  task automatic offer_access(input access_t acc, input logic typed,
                              input response_t typed_resp, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= acc.command;
    byte_swap_i  <= acc.byte_swap;
    address_i    <= acc.address;
    count_i      <= acc.count;
    write_data_i <= acc.write_data;
    row_typed    <= typed;
    row_expect   <= typed_resp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Draw the sender's idle gap; every fourth stretch of 128 accesses runs flat out.
  function automatic int unsigned sender_gap(input int unsigned n);
    return (((n / 128) % 4) == 3) ? 0 : $urandom_range(0, 15);
  endfunction

  // Scoreboard: predict on every input transfer, check on every output
  // transfer. Prediction comes first so a same-edge pair stays in order.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      seen_access.command    = cmd_e'(command_i);
      seen_access.byte_swap  = byte_swap_i;
      seen_access.address    = address_i;
      seen_access.count      = count_i;
      seen_access.write_data = write_data_i;
      model_resp = apply_access(seen_access);
      awaited_responses.push_back(row_typed ? row_expect : model_resp);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_resp.read_data = read_data_o;
      seen_resp.in_range  = in_range_o;
      if (awaited_responses.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected result read_data=%h in_range=%b",
                   $realtime, seen_resp.read_data, seen_resp.in_range);
      end else begin
        want_resp = awaited_responses.pop_front();
        if (seen_resp.read_data !== want_resp.read_data ||
            seen_resp.in_range !== want_resp.in_range) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result mismatch read_data exp %h got %h, in_range exp %b got %b",
                     $realtime, want_resp.read_data, seen_resp.read_data,
                     want_resp.in_range, seen_resp.in_range);
        end
      end
    end
  end

  // Receiver: stall for a drawn number of cycles before each result, with
  // every fourth stretch of 96 results taken without stalling.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      pick = (((result_count / 96) % 4) == 1) ? 0 : $urandom_range(0, 15);
      if (pick != 0) begin
        out_ready_i <= 1'b0;
        repeat (pick) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      result_count++;
    end
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_RD_REG;
    byte_swap_i  <= 1'b0;
    address_i    <= '0;
    count_i      <= '0;
    write_data_i <= '0;
    row_typed    <= 1'b0;
    row_expect   <= '0;
    for (int unsigned w = 0; w < STORE_WORDS; w++) store_image[w] = '0;

    // Hold reset, then release it; the block then clears itself with ready low.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table first.
    for (int unsigned r = 0; r < DIRECTED_ROWS; r++)
      offer_access(directed_rows[r].acc, directed_rows[r].typed,
                   directed_rows[r].resp, sender_gap(r));

    // Random accesses, mostly aimed at two hot windows so that reads land
    // on data written a little earlier; the rest sweep the whole store or address field.
    for (int unsigned n = 0; n < RANDOM_ACCESSES; n++) begin
      next_access.command    = cmd_e'($urandom_range(0, 3));
      next_access.byte_swap  = 1'($urandom_range(0, 1));
      next_access.write_data = WORD_W'($urandom);
      next_access.count      = COUNT_W'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                                    : $urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (next_access.command == CMD_RD_REG || next_access.command == CMD_WR_REG) begin
        if (pick < 45)      next_access.address = ADDR_W'($urandom_range(0, 15));
        else if (pick < 60) next_access.address = ADDR_W'($urandom_range(STORE_WORDS - 16,
                                                                         STORE_WORDS - 1));
        else if (pick < 90) next_access.address = ADDR_W'($urandom_range(0, STORE_WORDS - 1));
        else                next_access.address = ADDR_W'($urandom_range(0, 16383));
      end else begin
        if (pick < 45)      next_access.address = ADDR_W'($urandom_range(0, 255));
        else if (pick < 65) next_access.address = ADDR_W'($urandom_range(16240, 16383));
        else                next_access.address = ADDR_W'($urandom_range(0, 16383));
      end
      offer_access(next_access, 1'b0, '0, sender_gap(n + DIRECTED_ROWS));
    end
    in_valid_i <= 1'b0;
    // let the scoreboard log the last transfer before the queue is polled
    @(posedge clk_i);

    // Drain: wait for every result, then watch for strays a little longer.
    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
